// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this block.
// Each macro checks one implication on the rising clock edge, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/dmc_pkg.sv -----
// Shared types and constants for the direct-mapped read cache.
// No dependencies; the files that use it refer to it by scoped names.
package dmc_pkg;

	localparam int ADDR_W = 12;
	localparam int BYTE_W = 8;
	localparam int MISS_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_W = 8;
	localparam int CFG_IDX_W = 1;

	// Geometry defaults; all three must be powers of two.
	localparam int LINE_SIZE_DEF = 16;
	localparam int LINE_COUNT_DEF = 8;
	localparam int RAM_SIZE_DEF = 4096;

	// Entries between the front and the back part.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_W-1:0] MISS_PENALTY_RST = 8'd10;
	localparam logic [CFG_W-1:0] HIT_COST_RST = 8'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIT_COST = 1'b1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_ACCESS = 1'b1;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_ACCESS = 1'b1
	} kind_t;

	typedef struct packed {
		logic command;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] load_byte;
	} item_t;

	typedef struct packed {
		logic hit;
		logic [BYTE_W-1:0] read_byte;
		logic [MISS_W-1:0] misses_so_far;
		logic [TIME_W-1:0] time_so_far;
	} result_t;

	// One classified item waiting for the back part.
	typedef struct packed {
		kind_t kind;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] load_byte;
	} entry_t;

endpackage

// ----- rtl/dmc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/dmc_front.sv -----
// Front part: accepts items, classifies them and queues them for the back part.
// Depends on dmc_pkg.
module dmc_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input dmc_pkg::item_t item,
	output logic busy,
	output logic hd_valid,
	output dmc_pkg::entry_t hd_entry,
	input logic pop
);

	localparam int PW = $clog2(dmc_pkg::QUEUE_DEPTH);

	dmc_pkg::entry_t slot_q [dmc_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] cnt_q;
	logic push;
	logic do_pop;
	dmc_pkg::entry_t new_entry;

	assign busy = (cnt_q == (PW+1)'(dmc_pkg::QUEUE_DEPTH));
	assign hd_valid = (cnt_q != '0);
	assign hd_entry = slot_q[rd_ptr_q];
	assign push = start && !busy;
	assign do_pop = pop && hd_valid;

	always_comb begin
		new_entry.kind = (item.command == dmc_pkg::CMD_ACCESS) ?
			dmc_pkg::KIND_ACCESS : dmc_pkg::KIND_LOAD;
		new_entry.address = item.address;
		new_entry.load_byte = item.load_byte;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			end
			case ({push, do_pop})
				2'b10: cnt_q <= (PW+1)'(cnt_q + 1'b1);
				2'b01: cnt_q <= (PW+1)'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/dmc_back.sv -----
// Back part: tag lookup, line fill from backing RAM, counters and the result.
// Depends on dmc_pkg and dmc_ram.
module dmc_back #(
	parameter int LINE_SIZE = dmc_pkg::LINE_SIZE_DEF,
	parameter int LINE_COUNT = dmc_pkg::LINE_COUNT_DEF,
	parameter int RAM_SIZE = dmc_pkg::RAM_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic hd_valid,
	input dmc_pkg::entry_t hd_entry,
	output logic pop,
	input logic [dmc_pkg::CFG_W-1:0] miss_penalty,
	input logic [dmc_pkg::CFG_W-1:0] hit_cost,
	output logic done,
	output dmc_pkg::result_t result
);

	localparam int OFF_W = $clog2(LINE_SIZE);
	localparam int LINE_W = $clog2(LINE_COUNT);
	localparam int RAM_AW = $clog2(RAM_SIZE);
	localparam int BLK_W = dmc_pkg::ADDR_W - OFF_W;
	localparam int LB_AW = LINE_W + OFF_W;
	localparam int TW = dmc_pkg::TIME_W;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_RD = 3'b010,
		B_FILL = 3'b100
	} back_state_t;

	back_state_t state_q;
	logic [LINE_COUNT-1:0] valid_q;
	logic [BLK_W-1:0] tag_q [LINE_COUNT];
	logic [dmc_pkg::MISS_W-1:0] miss_q;
	logic [TW-1:0] time_q;
	logic [BLK_W-1:0] blk_q;
	logic [LINE_W-1:0] line_q;
	logic [OFF_W-1:0] off_q;
	logic [OFF_W-1:0] cnt_q;
	logic [dmc_pkg::BYTE_W-1:0] byte_q;

	logic [BLK_W-1:0] hd_blk;
	logic [LINE_W-1:0] hd_line;
	logic [OFF_W-1:0] hd_off;
	logic is_access;
	logic is_load;
	logic hd_hit;
	logic last;
	logic [TW:0] time_sum;
	logic [TW-1:0] time_sat;
	logic [dmc_pkg::CFG_W-1:0] time_inc;

	logic ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [RAM_AW-1:0] ram_raddr;
	logic [dmc_pkg::BYTE_W-1:0] ram_rdata;
	logic lb_we;
	logic [dmc_pkg::BYTE_W-1:0] lb_rdata;

	assign hd_blk = hd_entry.address[dmc_pkg::ADDR_W-1:OFF_W];
	assign hd_line = LINE_W'(hd_blk);
	assign hd_off = hd_entry.address[OFF_W-1:0];
	assign pop = (state_q == B_IDLE) && hd_valid;
	assign is_access = pop && (hd_entry.kind == dmc_pkg::KIND_ACCESS);
	assign is_load = pop && (hd_entry.kind == dmc_pkg::KIND_LOAD);
	assign hd_hit = valid_q[hd_line] && (tag_q[hd_line] == hd_blk);
	assign last = (cnt_q == OFF_W'(LINE_SIZE - 1));

	// The access cost is added when the item is taken, the miss penalty on the
	// first fill cycle, so each cycle holds at most one saturating add.
	assign time_inc = (state_q == B_FILL) ? miss_penalty : hit_cost;
	assign time_sum = {1'b0, time_q} + (TW+1)'(time_inc);
	assign time_sat = time_sum[TW] ? '1 : time_sum[TW-1:0];

	assign ram_we = is_load;
	assign ram_waddr = RAM_AW'(hd_entry.address);
	assign ram_raddr = (state_q == B_FILL) ?
		RAM_AW'({blk_q, OFF_W'(cnt_q + 1'b1)}) : RAM_AW'({hd_blk, OFF_W'(0)});
	assign lb_we = (state_q == B_FILL);

	dmc_ram #(
		.WIDTH(dmc_pkg::BYTE_W),
		.DEPTH(RAM_SIZE)
	) u_backing (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(hd_entry.load_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	dmc_ram #(
		.WIDTH(dmc_pkg::BYTE_W),
		.DEPTH(LINE_COUNT * LINE_SIZE)
	) u_lines (
		.clk(clk),
		.we(lb_we),
		.waddr(LB_AW'({line_q, cnt_q})),
		.wdata(ram_rdata),
		.raddr(LB_AW'({hd_line, hd_off})),
		.rdata(lb_rdata)
	);

	always_ff @(posedge clk) begin
		if (is_access) begin
			blk_q <= hd_blk;
			line_q <= hd_line;
			off_q <= hd_off;
			if (!hd_hit) begin
				tag_q[hd_line] <= hd_blk;
			end
		end
		if (state_q == B_FILL && cnt_q == off_q) begin
			byte_q <= ram_rdata;
		end
		if (state_q == B_RD) begin
			result.hit <= 1'b1;
			result.read_byte <= lb_rdata;
			result.misses_so_far <= miss_q;
			result.time_so_far <= time_q;
		end else if (state_q == B_FILL && last) begin
			result.hit <= 1'b0;
			result.read_byte <= (cnt_q == off_q) ? ram_rdata : byte_q;
			result.misses_so_far <= miss_q;
			result.time_so_far <= time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= '0;
			miss_q <= '0;
			time_q <= '0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (state_q == B_RD) || (state_q == B_FILL && last);
			case (state_q)
				B_IDLE: begin
					cnt_q <= '0;
					if (is_access) begin
						time_q <= time_sat;
						if (hd_hit) begin
							state_q <= B_RD;
						end else begin
							valid_q[hd_line] <= 1'b1;
							if (miss_q != '1) begin
								miss_q <= miss_q + 1'b1;
							end
							state_q <= B_FILL;
						end
					end
				end
				B_RD: begin
					state_q <= B_IDLE;
				end
				B_FILL: begin
					if (cnt_q == '0) begin
						time_q <= time_sat;
					end
					cnt_q <= OFF_W'(cnt_q + 1'b1);
					if (last) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/direct_mapped_cache_read_top.sv -----
// Direct-mapped read cache. A load writes the backing RAM as the back part takes
// it; a hit takes its byte from the line buffer in state B_RD, and a miss
// refills the line one byte a cycle from the backing RAM read port in B_FILL.
// The back part takes no new item until its current access is done.
// A two-entry queue holds items while the back part works; busy marks it full.
// Reset clears valid bits, counters and state and restores the cost settings; RAM contents are kept.
module direct_mapped_cache_read_top #(
	parameter int LINE_SIZE = dmc_pkg::LINE_SIZE_DEF,
	parameter int LINE_COUNT = dmc_pkg::LINE_COUNT_DEF,
	parameter int RAM_SIZE = dmc_pkg::RAM_SIZE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input dmc_pkg::item_t item,
	output logic busy,
	output logic done,
	output dmc_pkg::result_t result,
	input logic cfg_we,
	input logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dmc_pkg::CFG_W-1:0] cfg_data
);

	logic [dmc_pkg::CFG_W-1:0] miss_penalty_q;
	logic [dmc_pkg::CFG_W-1:0] hit_cost_q;
	logic hd_valid;
	dmc_pkg::entry_t hd_entry;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_penalty_q <= dmc_pkg::MISS_PENALTY_RST;
			hit_cost_q <= dmc_pkg::HIT_COST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dmc_pkg::CFG_MISS_PENALTY: miss_penalty_q <= cfg_data;
				dmc_pkg::CFG_HIT_COST: hit_cost_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dmc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.hd_valid(hd_valid),
		.hd_entry(hd_entry),
		.pop(pop)
	);

	dmc_back #(
		.LINE_SIZE(LINE_SIZE),
		.LINE_COUNT(LINE_COUNT),
		.RAM_SIZE(RAM_SIZE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.hd_valid(hd_valid),
		.hd_entry(hd_entry),
		.pop(pop),
		.miss_penalty(miss_penalty_q),
		.hit_cost(hit_cost_q),
		.done(done),
		.result(result)
	);

endmodule

// ----- rtl/dmc_checker.sv -----
// Port-level checks for the direct-mapped read cache, bound to the top level.
// Depends on dmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input dmc_pkg::result_t result
);

	// The back part returns to idle after each result, so results never come back to back.
	`ASSERT_NEXT(a_done_spaced, clk, arst_n, done, !done)
	// A miss has always been counted by the time its result appears.
	`ASSERT_SAME(a_miss_counted, clk, arst_n, done && !result.hit, result.misses_so_far != '0)
	// The queue only fills up after an item was taken in the cycle before.
	`ASSERT_SAME(a_busy_cause, clk, arst_n, $rose(busy), $past(start))

endmodule

bind direct_mapped_cache_read_top dmc_checker u_dmc_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Testbench for direct_mapped_cache_read_top. It drives load and read items through the
// command port, predicts every read result, and checks each one when its strobe arrives.
// It depends on dmc_pkg and the top module only.
module tb;

	localparam int ADDR_W = dmc_pkg::ADDR_W;
	localparam int BYTE_W = dmc_pkg::BYTE_W;
	localparam int MISS_W = dmc_pkg::MISS_W;
	localparam int TIME_W = dmc_pkg::TIME_W;
	localparam int CFG_W = dmc_pkg::CFG_W;
	localparam int CFG_IDX_W = dmc_pkg::CFG_IDX_W;
	localparam int LINE_BYTES = 16;
	localparam int LINES = 8;
	localparam int RAM_BYTES = 4096;
	localparam int BLOCKS = RAM_BYTES / LINE_BYTES;
	localparam int MAX_FILLED = 40;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int PHASES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	dmc_pkg::item_t item = '0;
	logic busy;
	logic done;
	dmc_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = dmc_pkg::CFG_MISS_PENALTY;
	logic [CFG_W-1:0] cfg_data = '0;

	// Shadow copy of the cache, the backing RAM and the counters.
	bit line_valid [LINES];
	logic [4:0] line_tag [LINES];
	logic [BYTE_W-1:0] line_data [LINES][LINE_BYTES];
	logic [BYTE_W-1:0] ram_image [RAM_BYTES];
	logic [MISS_W-1:0] miss_count;
	logic [TIME_W-1:0] time_count;
	logic [CFG_W-1:0] miss_penalty;
	logic [CFG_W-1:0] hit_cost;

	dmc_pkg::result_t pending_reads [$];
	bit block_ready [BLOCKS];
	int filled_blocks [$];
	int recent_blocks [$];
	int idle_pct;
	int n_loads, n_reads, n_hits, n_settings;
	int mismatches;
	int cycles;

	direct_mapped_cache_read_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[direct_mapped_cache_read_top] ERROR");
			$finish;
		end
	end

	function automatic void note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic logic [TIME_W-1:0] time_add(input logic [TIME_W-1:0] t,
			input logic [CFG_W-1:0] d);
		logic [TIME_W:0] sum;
		sum = {1'b0, t} + (TIME_W+1)'(d);
		return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	endfunction

	function automatic void reset_shadow();
		for (int i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_tag[i] = '0;
			for (int j = 0; j < LINE_BYTES; j++)
				line_data[i][j] = '0;
		end
		miss_count = '0;
		time_count = '0;
		miss_penalty = dmc_pkg::MISS_PENALTY_RST;
		hit_cost = dmc_pkg::HIT_COST_RST;
	endfunction

	// Applies one accepted item to the shadow state and queues the read result it causes.
	function automatic void cache_apply(input dmc_pkg::item_t it);
		int blk;
		int ln;
		int off;
		logic [4:0] tg;
		bit was_hit;
		dmc_pkg::result_t r;
		if (it.command == dmc_pkg::CMD_LOAD) begin
			ram_image[it.address] = it.load_byte;
			n_loads++;
			return;
		end
		off = int'(it.address[3:0]);
		blk = int'(it.address[11:4]);
		ln = blk % LINES;
		tg = 5'(blk / LINES);
		time_count = time_add(time_count, hit_cost);
		was_hit = line_valid[ln] && line_tag[ln] == tg;
		if (!was_hit) begin
			if (miss_count != '1)
				miss_count++;
			line_valid[ln] = 1'b1;
			line_tag[ln] = tg;
			for (int i = 0; i < LINE_BYTES; i++)
				line_data[ln][i] = ram_image[blk * LINE_BYTES + i];
			time_count = time_add(time_count, miss_penalty);
		end else begin
			n_hits++;
		end
		r.hit = was_hit;
		r.read_byte = line_data[ln][off];
		r.misses_so_far = miss_count;
		r.time_so_far = time_count;
		pending_reads.push_back(r);
		n_reads++;
	endfunction

	always @(posedge clk) begin : check_results
		dmc_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_reads.size() == 0) begin
				note_failure($sformatf("unexpected result hit=%0b byte=%02h", result.hit,
					result.read_byte));
			end else begin
				want = pending_reads.pop_front();
				if (result.hit !== want.hit || result.read_byte !== want.read_byte
						|| result.misses_so_far !== want.misses_so_far
						|| result.time_so_far !== want.time_so_far)
					note_failure($sformatf({"expected hit=%0b byte=%02h misses=%0d ",
						"time=%0d, got hit=%0b byte=%02h misses=%0d time=%0d"},
						want.hit, want.read_byte, want.misses_so_far, want.time_so_far,
						result.hit, result.read_byte, result.misses_so_far,
						result.time_so_far));
			end
		end
	end

	// Holds start high across back-to-back items; a random idle burst lowers it first.
	task automatic send_item(input dmc_pkg::item_t it);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		cache_apply(it);
	endtask

	task automatic load_at(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] val);
		send_item(dmc_pkg::item_t'{command: dmc_pkg::CMD_LOAD, address: addr,
			load_byte: val});
	endtask

	task automatic read_at(input logic [ADDR_W-1:0] addr);
		send_item(dmc_pkg::item_t'{command: dmc_pkg::CMD_ACCESS, address: addr,
			load_byte: 8'($urandom_range(0, 255))});
	endtask

	// Loads every byte of a block so that a later fill never reads unwritten RAM.
	task automatic fill_block(input int blk);
		for (int i = 0; i < LINE_BYTES; i++)
			load_at(ADDR_W'(blk * LINE_BYTES + i), 8'($urandom_range(0, 255)));
		if (!block_ready[blk]) begin
			block_ready[blk] = 1'b1;
			filled_blocks.push_back(blk);
		end
	endtask

	// Trailing loads give no result, so a settling wait follows once the reads are in.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == dmc_pkg::CFG_MISS_PENALTY)
			miss_penalty = val;
		else
			hit_cost = val;
	endtask

	task automatic set_costs(input logic [CFG_W-1:0] penalty, input logic [CFG_W-1:0] cost);
		wait_idle();
		write_reg(dmc_pkg::CFG_MISS_PENALTY, penalty);
		write_reg(dmc_pkg::CFG_HIT_COST, cost);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Cold misses on the lowest and highest blocks, then hits at other bytes.
	task automatic test_cold_reads();
		fill_block(0);
		fill_block(BLOCKS - 1);
		load_at(12'h000, 8'h00);
		load_at(12'h00F, 8'hFF);
		load_at(12'hFF0, 8'hFF);
		load_at(12'hFFF, 8'h00);
		read_at(12'h000);
		read_at(12'h00F);
		read_at(12'hFFF);
		read_at(12'hFF0);
		read_at(12'h007);
	endtask

	// A load under a cached line must not show until a conflicting tag evicts the line.
	task automatic test_stale_line();
		load_at(12'h005, 8'($urandom_range(0, 255)));
		read_at(12'h005);
		fill_block(8);
		read_at(12'h080);
		read_at(12'h005);
		read_at(12'h08A);
	endtask

	task automatic test_cost_extremes();
		set_costs(8'd255, 8'd255);
		read_at(12'h000);
		read_at(12'hFF3);
		read_at(12'h080);
		set_costs(8'd0, 8'd0);
		read_at(12'h001);
		read_at(12'h002);
		set_costs(8'd0, 8'd255);
		read_at(12'h08F);
		read_at(12'h080);
		set_costs(8'd255, 8'd0);
		read_at(12'h000);
		read_at(12'h00F);
	endtask

	function automatic logic [CFG_W-1:0] pick_cost();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return CFG_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly reads with locality over filled blocks, plus stray loads and new block fills.
	task automatic test_random(input int total);
		int sent;
		int r;
		int blk;
		for (int ph = 0; ph < PHASES; ph++) begin
			set_costs(pick_cost(), pick_cost());
			idle_pct = (ph == PHASES - 1) ? 0 : $urandom_range(0, 2) * 20;
			sent = 0;
			while (sent < total / PHASES) begin
				r = $urandom_range(0, 99);
				if (r < 5 && filled_blocks.size() < MAX_FILLED) begin
					do
						blk = $urandom_range(0, BLOCKS - 1);
					while (block_ready[blk]);
					fill_block(blk);
					sent += LINE_BYTES;
				end else if (r < 25) begin
					load_at(ADDR_W'($urandom_range(0, RAM_BYTES - 1)),
						8'($urandom_range(0, 255)));
					sent++;
				end else begin
					if (recent_blocks.size() != 0 && $urandom_range(0, 1) == 1)
						blk = recent_blocks[$urandom_range(0, recent_blocks.size() - 1)];
					else
						blk = filled_blocks[$urandom_range(0, filled_blocks.size() - 1)];
					read_at(ADDR_W'(blk * LINE_BYTES + $urandom_range(0, LINE_BYTES - 1)));
					recent_blocks.push_back(blk);
					if (recent_blocks.size() > 4)
						void'(recent_blocks.pop_front());
					sent++;
				end
			end
		end
	endtask

	initial begin
		reset_shadow();
		idle_pct = 25;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cold_reads();
		test_stale_line();
		test_cost_extremes();
		test_random(RANDOM_ITEMS);
		wait_idle();
		$display("Covered %0d reads (%0d hits, %0d misses) and %0d loads", n_reads, n_hits,
			n_reads - n_hits, n_loads);
		$display("over %0d cost settings; %0d mismatches.", n_settings, mismatches);
		if (mismatches == 0)
			$display("[direct_mapped_cache_read_top] OK");
		else
			$display("[direct_mapped_cache_read_top] ERROR");
		$finish;
	end

endmodule
